@@ design/msu_pkg.sv @@
`default_nettype none
package msu_pkg;

  // Default sizes
  localparam int MAX_SYMBOLS_DEF = 8;
  localparam int LENGTH_BITS_DEF = 24;

  // Field widths fixed by the item format
  localparam int SYMBOL_W   = 8;
  localparam int FRACTION_W = 17;
  localparam int RANDOM_W   = 31;
  localparam int FRAC_BITS  = 16;

  // 1.0 in the fraction format
  localparam logic [FRACTION_W-1:0] ONE_FIX = FRACTION_W'(1 << FRAC_BITS);

  // Mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_LOADED = 2'd0;
  localparam logic [1:0] STATUS_DRAWN  = 2'd1;
  localparam logic [1:0] STATUS_ERROR  = 2'd2;

  typedef struct packed {
    logic                  mode;
    logic                  first;
    logic [SYMBOL_W-1:0]   symbol;
    logic [FRACTION_W-1:0] fraction;
    logic [RANDOM_W-1:0]   random_value;
  } in_item_t;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol_out;
    logic [1:0]          status;
    logic                last;
  } out_item_t;

endpackage
`default_nettype wire

@@ design/multiset_urn_sampler.sv @@
`default_nettype none
// Load item: LD_MUL, LD_ADD, LD_SET (multiply, accumulate, settle), then RESULT.
// Draw item: bit-serial modulo of the random value in one subtract/compare unit,
//   then a walk over the tables unless they are empty, then DR_FIN and RESULT.
// Only one item is in flight; a stalled output item does not block the next accept.
// rst (synchronous, active high) clears control state, chunk_length, entry count,
//   totals and remaining draws; the symbol and count RAMs are not cleared.
module multiset_urn_sampler
  import msu_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [LENGTH_BITS-1:0] cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_item_t               in_item,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_item
);

  localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int BIT_W = $clog2(RANDOM_W);
  localparam int PROD_W = LENGTH_BITS + FRACTION_W;

  typedef enum logic [2:0] {
    IDLE, LD_MUL, LD_ADD, LD_SET, DR_DIV, DR_WALK, DR_FIN, RESULT
  } state_t;

  state_t                 state;
  in_item_t               item;
  out_item_t              res;
  logic [LENGTH_BITS-1:0] chunk_length;
  logic [CNT_W-1:0]       entry_count;
  logic [LENGTH_BITS-1:0] assigned_total;
  logic [LENGTH_BITS-1:0] remaining_draws;
  logic [LENGTH_BITS-1:0] first_count;
  logic [SYMBOL_W-1:0]    last_symbol;
  logic [PROD_W-1:0]      prod;
  logic [LENGTH_BITS-1:0] rem_acc;
  logic [BIT_W-1:0]       bit_idx;
  logic [IDX_W-1:0]       idx;
  logic                   hit;
  logic [SYMBOL_W-1:0]    hit_symbol;

  // RAM ports
  logic                   sym_we;
  logic [IDX_W-1:0]       rd_addr;
  logic [SYMBOL_W-1:0]    sym_rd;
  logic                   cnt_we;
  logic [LENGTH_BITS-1:0] cnt_wdata;
  logic [LENGTH_BITS-1:0] cnt_rd;

  // Combinational helpers
  logic [CNT_W-1:0]       eff_count;
  logic                   ld_err;
  logic [FRACTION_W-1:0]  frac_clamp;
  logic [LENGTH_BITS-1:0] num;
  logic [LENGTH_BITS:0]   sum;
  logic [LENGTH_BITS:0]   shifted;
  logic                   sub_ok;
  logic [LENGTH_BITS-1:0] walk_cnt;
  logic                   walk_hit;
  logic                   walk_end;
  logic                   out_free;

  // Load checks: a first flag empties the table before the entry goes in
  always_comb begin
    eff_count  = item.first ? '0 : entry_count;
    ld_err     = (eff_count >= CNT_W'(MAX_SYMBOLS)) ||
                 ((eff_count != '0) && (item.symbol <= last_symbol));
    frac_clamp = (item.fraction > ONE_FIX) ? ONE_FIX : item.fraction;
    num        = prod[FRAC_BITS +: LENGTH_BITS];
    sum        = {1'b0, assigned_total} + {1'b0, num};
  end

  // Modulo subtract/compare: one restoring modulo step
  always_comb begin
    shifted = {rem_acc, item.random_value[bit_idx]};
    sub_ok  = (shifted >= {1'b0, remaining_draws});
  end

  // Walk step over the entry whose data the RAMs present now
  always_comb begin
    walk_cnt = (idx == '0) ? first_count : cnt_rd;
    walk_hit = (rem_acc < walk_cnt);
    walk_end = ((CNT_W'(idx) + CNT_W'(1)) == entry_count);
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != IDLE);

  // RAM control
  always_comb begin
    rd_addr   = (state == DR_WALK) ? IDX_W'(idx + 1'b1) : '0;
    sym_we    = (state == LD_MUL) && !ld_err;
    cnt_we    = ((state == LD_ADD) || ((state == DR_WALK) && walk_hit)) && (idx != '0);
    cnt_wdata = (state == LD_ADD) ? num : LENGTH_BITS'(walk_cnt - 1'b1);
  end

  msu_ram #(
    .WIDTH(SYMBOL_W),
    .DEPTH(MAX_SYMBOLS)
  ) u_sym_ram (
    .clk    (clk),
    .wr_en  (sym_we),
    .wr_addr(eff_count[IDX_W-1:0]),
    .wr_data(item.symbol),
    .rd_addr(rd_addr),
    .rd_data(sym_rd)
  );

  msu_ram #(
    .WIDTH(LENGTH_BITS),
    .DEPTH(MAX_SYMBOLS)
  ) u_cnt_ram (
    .clk    (clk),
    .wr_en  (cnt_we),
    .wr_addr(idx),
    .wr_data(cnt_wdata),
    .rd_addr(rd_addr),
    .rd_data(cnt_rd)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      out_valid       <= 1'b0;
      chunk_length    <= '0;
      entry_count     <= '0;
      assigned_total  <= '0;
      remaining_draws <= '0;
      first_count     <= '0;
    end else begin
      // Output register drains; RESULT reloads it itself
      if (out_valid && !out_stall && (state != RESULT)) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        chunk_length <= cfg_data;
      end

      unique case (state)
        IDLE: begin
          if (in_valid) begin
            item <= in_item;
            if (in_item.mode == MODE_LOAD) begin
              state <= LD_MUL;
            end else if (remaining_draws == '0) begin
              res   <= '{symbol_out: '0, status: STATUS_ERROR, last: 1'b0};
              state <= RESULT;
            end else begin
              rem_acc <= '0;
              bit_idx <= BIT_W'(RANDOM_W - 1);
              state   <= DR_DIV;
            end
          end
        end

        LD_MUL: begin
          if (item.first) begin
            entry_count    <= '0;
            assigned_total <= '0;
          end
          if (ld_err) begin
            res   <= '{symbol_out: '0, status: STATUS_ERROR, last: 1'b0};
            state <= RESULT;
          end else begin
            idx         <= eff_count[IDX_W-1:0];
            last_symbol <= item.symbol;
            prod        <= PROD_W'(chunk_length) * PROD_W'(frac_clamp);
            state       <= LD_ADD;
          end
        end

        LD_ADD: begin
          if (idx == '0) begin
            assigned_total <= '0;
          end else if (sum[LENGTH_BITS]) begin
            assigned_total <= '1;
          end else begin
            assigned_total <= sum[LENGTH_BITS-1:0];
          end
          entry_count <= entry_count + 1'b1;
          state       <= LD_SET;
        end

        LD_SET: begin
          remaining_draws <= chunk_length;
          if (assigned_total > chunk_length) begin
            first_count <= '0;
            res <= '{symbol_out: '0, status: STATUS_ERROR, last: 1'b0};
          end else begin
            first_count <= chunk_length - assigned_total;
            res <= '{symbol_out: '0, status: STATUS_LOADED, last: 1'b0};
          end
          state <= RESULT;
        end

        DR_DIV: begin
          rem_acc <= sub_ok ? LENGTH_BITS'(shifted - {1'b0, remaining_draws})
                            : shifted[LENGTH_BITS-1:0];
          if (bit_idx == '0) begin
            idx <= '0;
            hit <= 1'b0;
            state <= (entry_count == '0) ? DR_FIN : DR_WALK;
          end else begin
            bit_idx <= bit_idx - 1'b1;
          end
        end

        DR_WALK: begin
          if (walk_hit) begin
            hit        <= 1'b1;
            hit_symbol <= sym_rd;
            if (idx == '0) begin
              first_count <= first_count - 1'b1;
            end
            state <= DR_FIN;
          end else begin
            rem_acc <= rem_acc - walk_cnt;
            if (walk_end) begin
              state <= DR_FIN;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        DR_FIN: begin
          remaining_draws <= remaining_draws - 1'b1;
          res.symbol_out  <= hit ? hit_symbol : '0;
          res.status      <= hit ? STATUS_DRAWN : STATUS_ERROR;
          res.last        <= (remaining_draws == LENGTH_BITS'(1));
          state           <= RESULT;
        end

        RESULT: begin
          if (out_free) begin
            out_item  <= res;
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

  // Checks
  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_SYMBOLS))
    else $error("entry count above table size");

  a_residual_bound: assert property (@(posedge clk) disable iff (rst)
    (state == DR_DIV || state == DR_WALK) |-> (rem_acc < remaining_draws))
    else $error("draw residual not below remaining draws");

  a_empty_draw: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE && in_valid && in_item.mode == MODE_DRAW && remaining_draws == '0)
    |=> (state == RESULT && res.status == STATUS_ERROR))
    else $error("draw with no draws left not flagged");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == RESULT && out_valid && out_stall) |=> (state == RESULT))
    else $error("pending result overwrote a stalled item");

endmodule
`default_nettype wire

@@ design/msu_ram.sv @@
`default_nettype none
module msu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
